>>> hdl/kst_pkg.sv
// Shared types and constants of the KST oscillator.
package kst_pkg;

    localparam int PRICE_W    = 32;
    localparam int LAG_W      = 7;
    localparam int ALPHA_W    = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int EMA_W      = 48;
    localparam int SUM_W      = 52;
    localparam int OUT_W      = 32;

    localparam logic [ALPHA_W-1:0] ONE_Q16     = 17'd65536;
    localparam int                 ALPHA_SHIFT = 16;
    localparam logic [EMA_W+17:0]  ROUND_HALF  = 66'd32768;
    localparam logic [EMA_W-1:0]   VAL_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [PRICE_W-1:0] KST_DIVISOR = 32'd10;
    localparam int                 KST_ROUND   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LAG_ONE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_TWO     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_THREE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_FOUR    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ONE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_TWO   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THREE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FOUR  = 4'd7;

    localparam logic [LAG_W-1:0]   RST_LAG_ONE     = 7'd10;
    localparam logic [LAG_W-1:0]   RST_LAG_TWO     = 7'd15;
    localparam logic [LAG_W-1:0]   RST_LAG_THREE   = 7'd20;
    localparam logic [LAG_W-1:0]   RST_LAG_FOUR    = 7'd30;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_SHORT = 17'd11916;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_LONG  = 17'd8192;

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic               restart;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] signal_value;
        logic                    zero_price_fault;
    } out_t;

endpackage

>>> hdl/kst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/kst_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module kst_div #(
    parameter int NW = 56,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NW-1]};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // subtract when the trial remainder covers the divisor
            rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            num_next = {num_reg[NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

>>> hdl/kst_mul.sv
// Bit-serial shift-and-add multiplier: signed value times unsigned Q1.16 weight.
module kst_mul #(
    parameter int DW = 49
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [DW-1:0]                  mcand,
    input  logic [kst_pkg::ALPHA_W-1:0]           mplier,
    output logic                                  done,
    output logic signed [DW+kst_pkg::ALPHA_W-1:0] product
);

    localparam int PW    = DW + kst_pkg::ALPHA_W;
    localparam int CNT_W = $clog2(kst_pkg::ALPHA_W + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [PW-1:0]        acc_reg, acc_next;
    logic signed [PW-1:0]        mc_reg, mc_next;
    logic [kst_pkg::ALPHA_W-1:0] mp_reg, mp_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mc_next   = PW'(mcand);
            mp_next   = mplier;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(kst_pkg::ALPHA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> hdl/know_sure_thing_oscillator.sv
// Know Sure Thing oscillator: top level with the sequencer and the working registers.
//
// Usage:
//   in_valid/in_ready/in_item carry one close price word (unsigned Q16.16) plus a
//   restart flag that opens a new series. out_valid/out_ready/out_item carry the
//   smoothed signal (signed Q16.16, saturated) and the zero-price fault flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the lag and alpha registers;
//   cfg_ready is always high and writes belong in idle periods only.
//   An item before the series holds as many samples as the largest lag gives no
//   result. A later item goes through the shared bit-serial divider, NW bits wide,
//   NW being the larger of 39+FRACTION_BITS and 52: four rates of change (but for
//   a zero old price) and the final divide by ten go through it one quotient bit
//   per cycle, and once the series is seeded the five averages go through a
//   serial multiplier.
//   One item is in work at a time; in_ready is high only while the block idles.
//   The result sits in an output register, so the next word is accepted while it
//   waits; if the receiver still stalls when the following result is ready, the
//   block holds that result until the register empties.
//   Reset clears the sample count, the series and the output valid flag, and loads
//   the default lags and weights; the price ring needs no clearing.
module know_sure_thing_oscillator #(
    parameter int MAX_LAG       = 64,
    parameter int SIGNAL_PERIOD = 9,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  kst_pkg::in_t                      in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output kst_pkg::out_t                     out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kst_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW     = $clog2(MAX_LAG);
    localparam int CW     = $clog2(MAX_LAG + 1);
    localparam int MAGW   = 39 + FRACTION_BITS;
    localparam int NW     = (MAGW > kst_pkg::SUM_W) ? MAGW : kst_pkg::SUM_W;
    localparam int EW     = kst_pkg::EMA_W;
    localparam int MDW    = EW + 1;
    localparam int PW     = MDW + kst_pkg::ALPHA_W;
    localparam int SIG_ALPHA_I = (131072 + (SIGNAL_PERIOD + 1) / 2) / (SIGNAL_PERIOD + 1);
    localparam logic [kst_pkg::ALPHA_W-1:0] SIG_ALPHA = kst_pkg::ALPHA_W'(SIG_ALPHA_I);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_OLD   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_EMA   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_KST   = 4'd7;
    localparam logic [3:0] S_KDIV  = 4'd8;
    localparam logic [3:0] S_SIG   = 4'd9;
    localparam logic [3:0] S_SMUL  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_STORE = 4'd12;

    logic [3:0]                  state_reg, state_next;
    logic [1:0]                  k_reg, k_next;
    logic [31:0]                 price_reg, price_next;
    logic                        neg_reg, neg_next;
    logic                        fault_reg, fault_next;
    logic                        seeded_reg, seeded_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic signed [EW-1:0]        ema_reg [4];
    logic signed [EW-1:0]        ema_next [4];
    logic signed [EW-1:0]        roc_reg, roc_next;
    logic signed [EW-1:0]        kst_reg, kst_next;
    logic signed [EW-1:0]        sig_reg, sig_next;
    logic signed [kst_pkg::SUM_W-1:0] sum_reg, sum_next;
    kst_pkg::out_t               out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;
    logic [kst_pkg::LAG_W-1:0]   lag_reg [4];
    logic [kst_pkg::ALPHA_W-1:0] alpha_reg [4];

    logic [CW-1:0]               lag_eff [4];
    logic [CW-1:0]               start_lag;
    logic [CW-1:0]               cnt_eff;
    logic [CW:0]                 wpx, lkx, idx_full;
    logic [AW-1:0]               raddr;
    logic [31:0]                 rdata;
    logic                        ram_we;
    logic [31:0]                 diff;
    logic [NW-1:0]               diffx;
    logic                        div_start, div_done;
    logic [NW-1:0]               div_num, div_q;
    logic [31:0]                 div_den;
    logic                        mul_start, mul_done;
    logic signed [MDW-1:0]       mul_a;
    logic [kst_pkg::ALPHA_W-1:0] mul_b, alpha_k;
    logic signed [PW-1:0]        mul_p;
    logic signed [PW-1:0]        delta;
    logic signed [kst_pkg::SUM_W-1:0] ema_ext, term;
    logic [kst_pkg::SUM_W-1:0]   sum_abs;

    // effective lags and the sample index at which results start
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (lag_reg[i] == '0)
            begin
                lag_eff[i] = CW'(1);
            end
            else if (int'(lag_reg[i]) > MAX_LAG)
            begin
                lag_eff[i] = CW'(MAX_LAG);
            end
            else
            begin
                lag_eff[i] = CW'(lag_reg[i]);
            end
        end
        start_lag = lag_eff[3];
        for (int i = 0; i < 3; i++)
        begin
            if (lag_eff[i] > start_lag)
            begin
                start_lag = lag_eff[i];
            end
        end
    end

    assign cnt_eff  = in_item.restart ? '0 : count_reg;
    assign wpx      = (CW + 1)'(wp_reg);
    assign lkx      = (CW + 1)'(lag_eff[k_reg]);
    assign idx_full = (wpx >= lkx) ? wpx - lkx : wpx + (CW + 1)'(MAX_LAG) - lkx;
    assign raddr    = idx_full[AW-1:0];
    assign alpha_k  = (alpha_reg[k_reg] > kst_pkg::ONE_Q16) ? kst_pkg::ONE_Q16
                                                            : alpha_reg[k_reg];
    assign diff     = (price_reg >= rdata) ? price_reg - rdata : rdata - price_reg;
    assign diffx    = NW'(diff);
    assign delta    = (mul_p + kst_pkg::ROUND_HALF) >>> kst_pkg::ALPHA_SHIFT;
    assign ema_ext  = kst_pkg::SUM_W'(ema_reg[k_reg]);
    assign sum_abs  = sum_reg[kst_pkg::SUM_W-1] ? kst_pkg::SUM_W'(-sum_reg)
                                                : kst_pkg::SUM_W'(sum_reg);

    // weight 1..4 of the current average
    always_comb
    begin
        case (k_reg)
            2'd0:    term = ema_ext;
            2'd1:    term = ema_ext <<< 1;
            2'd2:    term = (ema_ext <<< 1) + ema_ext;
            default: term = ema_ext <<< 2;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        price_next     = price_reg;
        neg_next       = neg_reg;
        fault_next     = fault_reg;
        seeded_next    = seeded_reg;
        count_next     = count_reg;
        wp_next        = wp_reg;
        ema_next       = ema_reg;
        roc_next       = roc_reg;
        kst_next       = kst_reg;
        sig_next       = sig_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = alpha_k;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    price_next = in_item.close_price;
                    count_next = cnt_eff;
                    if (in_item.restart)
                    begin
                        seeded_next = 1'b0;
                    end
                    if (cnt_eff >= start_lag)
                    begin
                        k_next     = 2'd0;
                        sum_next   = '0;
                        fault_next = 1'b0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_STORE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                if (rdata == '0)
                begin
                    fault_next = 1'b1;
                    roc_next   = kst_pkg::VAL_MAX;
                    state_next = S_EMA;
                end
                else
                begin
                    neg_next   = (price_reg < rdata);
                    div_start  = 1'b1;
                    div_num    = (((diffx << 6) + (diffx << 5) + (diffx << 2))
                                  << FRACTION_BITS) + NW'(rdata >> 1);
                    div_den    = rdata;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        roc_next = -EW'(div_q);
                    end
                    else if (div_q > NW'(kst_pkg::VAL_MAX))
                    begin
                        roc_next = kst_pkg::VAL_MAX;
                    end
                    else
                    begin
                        roc_next = EW'(div_q);
                    end
                    state_next = S_EMA;
                end
            end
            S_EMA:
            begin
                if (seeded_reg)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MDW'(roc_reg) - MDW'(ema_reg[k_reg]);
                    state_next = S_MUL;
                end
                else
                begin
                    ema_next[k_reg] = roc_reg;
                    state_next      = S_ACC;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    ema_next[k_reg] = ema_reg[k_reg] + EW'(delta);
                    state_next      = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next = sum_reg + term;
                if (k_reg == 2'd3)
                begin
                    state_next = S_KST;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_KST:
            begin
                // divide by ten, rounding half away from zero
                div_start  = 1'b1;
                div_num    = NW'(sum_abs) + NW'(kst_pkg::KST_ROUND);
                div_den    = kst_pkg::KST_DIVISOR;
                neg_next   = sum_reg[kst_pkg::SUM_W-1];
                state_next = S_KDIV;
            end
            S_KDIV:
            begin
                if (div_done)
                begin
                    kst_next   = neg_reg ? -EW'(div_q) : EW'(div_q);
                    state_next = S_SIG;
                end
            end
            S_SIG:
            begin
                if (seeded_reg)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MDW'(kst_reg) - MDW'(sig_reg);
                    mul_b      = SIG_ALPHA;
                    state_next = S_SMUL;
                end
                else
                begin
                    sig_next   = kst_reg;
                    state_next = S_DONE;
                end
            end
            S_SMUL:
            begin
                if (mul_done)
                begin
                    sig_next   = sig_reg + EW'(delta);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    if (sig_reg > EW'(32'sh7FFF_FFFF))
                    begin
                        out_next.signal_value = 32'sh7FFF_FFFF;
                    end
                    else if (sig_reg < -EW'(33'sh0_8000_0000))
                    begin
                        out_next.signal_value = 32'sh8000_0000;
                    end
                    else
                    begin
                        out_next.signal_value = sig_reg[31:0];
                    end
                    out_next.zero_price_fault = fault_reg;
                    out_valid_next = 1'b1;
                    seeded_next    = 1'b1;
                    state_next     = S_STORE;
                end
            end
            S_STORE:
            begin
                ram_we  = 1'b1;
                wp_next = (wp_reg == AW'(MAX_LAG - 1)) ? '0 : wp_reg + 1'b1;
                if (count_reg < CW'(MAX_LAG))
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    kst_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LAG)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (price_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    kst_div #(
        .NW (NW),
        .DW (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    kst_mul #(
        .DW (MDW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            seeded_reg    <= 1'b0;
            count_reg     <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            lag_reg[0]    <= kst_pkg::RST_LAG_ONE;
            lag_reg[1]    <= kst_pkg::RST_LAG_TWO;
            lag_reg[2]    <= kst_pkg::RST_LAG_THREE;
            lag_reg[3]    <= kst_pkg::RST_LAG_FOUR;
            alpha_reg[0]  <= kst_pkg::RST_ALPHA_SHORT;
            alpha_reg[1]  <= kst_pkg::RST_ALPHA_SHORT;
            alpha_reg[2]  <= kst_pkg::RST_ALPHA_SHORT;
            alpha_reg[3]  <= kst_pkg::RST_ALPHA_LONG;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            seeded_reg    <= seeded_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    kst_pkg::CFG_LAG_ONE:     lag_reg[0]   <= cfg_data[kst_pkg::LAG_W-1:0];
                    kst_pkg::CFG_LAG_TWO:     lag_reg[1]   <= cfg_data[kst_pkg::LAG_W-1:0];
                    kst_pkg::CFG_LAG_THREE:   lag_reg[2]   <= cfg_data[kst_pkg::LAG_W-1:0];
                    kst_pkg::CFG_LAG_FOUR:    lag_reg[3]   <= cfg_data[kst_pkg::LAG_W-1:0];
                    kst_pkg::CFG_ALPHA_ONE:   alpha_reg[0] <= cfg_data;
                    kst_pkg::CFG_ALPHA_TWO:   alpha_reg[1] <= cfg_data;
                    kst_pkg::CFG_ALPHA_THREE: alpha_reg[2] <= cfg_data;
                    kst_pkg::CFG_ALPHA_FOUR:  alpha_reg[3] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        neg_reg   <= neg_next;
        fault_reg <= fault_next;
        ema_reg   <= ema_next;
        roc_reg   <= roc_next;
        kst_reg   <= kst_next;
        sig_reg   <= sig_next;
        sum_reg   <= sum_next;
        out_reg   <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

>>> hdl/kst_chk.sv
// Port-level checker for the KST oscillator and its bind.
module kst_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input kst_pkg::out_t out_item
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result word changed while stalled");

    // one word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // a new result appears while the ring write of its word is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result raised with the block already idle");

endmodule

bind know_sure_thing_oscillator kst_chk u_kst_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

>>> verif/know_sure_thing_oscillator_tb.sv
// Self-checking testbench of the KST oscillator: directed and random price streams.
module know_sure_thing_oscillator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RING_DEPTH   = 64;
    localparam logic [kst_pkg::ALPHA_W-1:0] SIG_ALPHA = kst_pkg::ALPHA_W'((2 * 65536 + 5) / 10);
    localparam longint ROC_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam int  SETTLE       = 20;
    localparam longint CYCLE_CAP = 6000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    kst_pkg::in_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    kst_pkg::out_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [kst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kst_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    know_sure_thing_oscillator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Predictor state
    logic [kst_pkg::LAG_W-1:0]   lag_reg [4];
    logic [kst_pkg::ALPHA_W-1:0] alpha_reg [4];
    logic [31:0]        price_hist [RING_DEPTH];
    int                 hist_pos;
    int                 series_len;
    bit                 series_seeded;
    longint             roc_avg [4];
    longint             signal_avg;

    kst_pkg::out_t signal_q [$];
    kst_pkg::out_t want;
    int     fail_count;
    int     items_sent;
    int     signals_seen;
    int     faults_seen;
    int     restarts_sent;
    longint cycle_count;
    int     burst_left;
    logic [31:0] walk_price;

    function automatic int clamp_lag(logic [kst_pkg::LAG_W-1:0] lag);
        if (lag < 1) return 1;
        if (lag > RING_DEPTH) return RING_DEPTH;
        return lag;
    endfunction

    function automatic longint smooth(longint avg, longint x,
                                      logic [kst_pkg::ALPHA_W-1:0] alpha);
        longint a;
        a = (alpha > 65536) ? 65536 : longint'(alpha);
        return (a * x + (65536 - a) * avg + 32768) >>> 16;
    endfunction

    function automatic longint rate_pct(logic [31:0] price, logic [31:0] old, inout bit fault);
        longint unsigned mag;
        longint unsigned q;
        if (old == 0)
        begin
            fault = 1'b1;
            return ROC_MAX;
        end
        mag = (longint'(price >= old ? price - old : old - price) * 100) << 16;
        q = (mag + longint'(old / 2)) / longint'(old);
        if (price >= old)
            return (q > ROC_MAX) ? ROC_MAX : longint'(q);
        return -longint'(q);
    endfunction

    function automatic void reset_predictor();
        lag_reg = '{kst_pkg::RST_LAG_ONE, kst_pkg::RST_LAG_TWO,
                    kst_pkg::RST_LAG_THREE, kst_pkg::RST_LAG_FOUR};
        alpha_reg = '{kst_pkg::RST_ALPHA_SHORT, kst_pkg::RST_ALPHA_SHORT,
                      kst_pkg::RST_ALPHA_SHORT, kst_pkg::RST_ALPHA_LONG};
        hist_pos = 0;
        series_len = 0;
        series_seeded = 0;
        roc_avg = '{0, 0, 0, 0};
        signal_avg = 0;
    endfunction

    // Work out the signal for one accepted price word, queue it if one is due.
    function automatic void predict_signal(kst_pkg::in_t item);
        int     lags [4];
        int     first;
        bit     fault;
        longint r;
        longint s;
        longint kst;
        longint sig;
        kst_pkg::out_t res;
        first = 0;
        fault = 0;
        for (int k = 0; k < 4; k++)
        begin
            lags[k] = clamp_lag(lag_reg[k]);
            if (lags[k] > first) first = lags[k];
        end
        if (item.restart)
        begin
            series_len = 0;
            series_seeded = 0;
        end
        if (series_len >= first)
        begin
            for (int k = 0; k < 4; k++)
            begin
                r = rate_pct(item.close_price,
                             price_hist[(hist_pos + RING_DEPTH - lags[k]) % RING_DEPTH], fault);
                roc_avg[k] = series_seeded ? smooth(roc_avg[k], r, alpha_reg[k]) : r;
            end
            s = roc_avg[0] + 2 * roc_avg[1] + 3 * roc_avg[2] + 4 * roc_avg[3];
            kst = (s >= 0) ? (s + 5) / 10 : -((-s + 5) / 10);
            signal_avg = series_seeded ? smooth(signal_avg, kst, SIG_ALPHA) : kst;
            series_seeded = 1;
            sig = signal_avg;
            if (sig > 64'sd2147483647) sig = 64'sd2147483647;
            if (sig < -64'sd2147483648) sig = -64'sd2147483648;
            res.signal_value = sig[31:0];
            res.zero_price_fault = fault;
            signal_q = {signal_q, res};
        end
        price_hist[hist_pos] = item.close_price;
        hist_pos = (hist_pos + 1) % RING_DEPTH;
        if (series_len < RING_DEPTH) series_len++;
    endfunction

    // Cycle cap
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("know_sure_thing_oscillator_tb: FAIL");
            $finish;
        end
    end

    // Receiver stalls: the mode follows bits 10:9 of the cycle count
    always @(posedge clk)
    begin
        case (cycle_count[10:9])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 1) == 0);
            2'd2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= (cycle_count[8:0] > 9'd400);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (signal_q.size() == 0)
            begin
                $error("signal word with nothing expected: %0d", out_item.signal_value);
                fail_count++;
            end
            else
            begin
                want = signal_q.pop_front();
                signals_seen++;
                if (want.zero_price_fault) faults_seen++;
                if (out_item.signal_value !== want.signal_value)
                begin
                    $error("signal_value expected %0d actual %0d",
                           want.signal_value, out_item.signal_value);
                    fail_count++;
                end
                if (out_item.zero_price_fault !== want.zero_price_fault)
                begin
                    $error("zero_price_fault expected %0b actual %0b",
                           want.zero_price_fault, out_item.zero_price_fault);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_price(logic [31:0] price, bit restart);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 450) : $urandom_range(0, 4);
            if ($urandom_range(0, 4) == 0) gap = 0;
            // drop valid only for a real gap, keep it up otherwise
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_item <= '{close_price: price, restart: restart};
        do @(posedge clk); while (!in_ready);
        predict_signal('{close_price: price, restart: restart});
        items_sent++;
        if (restart) restarts_sent++;
        burst_left--;
    endtask

    task automatic write_reg(logic [kst_pkg::CFG_IDX_W-1:0] idx,
                             logic [kst_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= kst_pkg::CFG_LAG_FOUR)
            lag_reg[idx[1:0]] = value[kst_pkg::LAG_W-1:0];
        else if (idx <= kst_pkg::CFG_ALPHA_FOUR)
            alpha_reg[2'(idx - kst_pkg::CFG_ALPHA_ONE)] = value;
    endtask

    // Hold off until every signal word is in and the block has gone quiet.
    task automatic drain();
        burst_left = 0;
        in_valid <= 1'b0;
        while (signal_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_regs(int l1, int l2, int l3, int l4, int a1, int a2, int a3, int a4);
        drain();
        write_reg(kst_pkg::CFG_LAG_ONE, kst_pkg::CFG_DATA_W'(l1));
        write_reg(kst_pkg::CFG_LAG_TWO, kst_pkg::CFG_DATA_W'(l2));
        write_reg(kst_pkg::CFG_LAG_THREE, kst_pkg::CFG_DATA_W'(l3));
        write_reg(kst_pkg::CFG_LAG_FOUR, kst_pkg::CFG_DATA_W'(l4));
        write_reg(kst_pkg::CFG_ALPHA_ONE, kst_pkg::CFG_DATA_W'(a1));
        write_reg(kst_pkg::CFG_ALPHA_TWO, kst_pkg::CFG_DATA_W'(a2));
        write_reg(kst_pkg::CFG_ALPHA_THREE, kst_pkg::CFG_DATA_W'(a3));
        write_reg(kst_pkg::CFG_ALPHA_FOUR, kst_pkg::CFG_DATA_W'(a4));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] next_price();
        case ($urandom_range(0, 99))
            0, 1:    return 32'd0;
            2, 3:    return $urandom_range(1, 3);
            4, 5, 6: return $urandom;
            7:       return 32'hFFFF_FFFF;
            default:
            begin
                if (walk_price < 32'd256) walk_price = $urandom;
                walk_price = walk_price + $urandom_range(0, walk_price >> 4) - (walk_price >> 5);
                return walk_price;
            end
        endcase
    endfunction

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            send_price(next_price(), n == 0 || $urandom_range(0, 59) == 0);
    endtask

    // Tiny lags, every alpha extreme, zero and full-scale prices.
    task automatic test_edge_prices();
        set_regs(1, 2, 3, 4, 1, 65536, 0, 131071);
        send_price(32'h0001_0000, 1);
        send_price(32'h0000_0001, 0);
        send_price(32'h0000_0000, 0);
        send_price(32'hFFFF_FFFF, 0);
        send_price(32'hFFFF_FFFF, 0);
        send_price(32'h0000_0001, 0);
        send_price(32'hFFFF_FFFF, 0);
        send_price(32'h0000_0000, 0);
        send_price(32'h0000_0000, 0);
        send_price(32'h8000_0000, 0);
        send_price(32'h7FFF_FFFF, 0);
        send_price(32'h0000_0000, 1);
        send_price(32'h0000_0005, 0);
        send_price(32'h5555_5555, 0);
        send_price(32'hAAAA_AAAA, 0);
        send_price(32'h0001_0000, 0);
        send_price(32'h0000_FFFF, 0);
        send_price(32'h0002_0000, 0);
        send_price(32'h0000_0000, 0);
        send_price(32'h0000_0003, 0);
    endtask

    // Writes to unused indexes must leave every register alone.
    task automatic test_unused_index();
        drain();
        write_reg(4'd8, 17'h1FFFF);
        write_reg(4'd15, 17'h00000);
        cfg_valid <= 1'b0;
        send_price(32'h0003_0000, 1);
        for (int n = 0; n < 5; n++) send_price(32'h0003_0000 + n * 32'h1000, 0);
    endtask

    task automatic test_random_phases();
        run_random(100);
        // Longest lags, full weights
        set_regs(64, 64, 64, 64, 65536, 65536, 65536, 65536);
        run_random(110);
        // Out-of-range lags, lag_four not the largest
        set_regs(0, 127, 64, 3, 0, 131071, 1, 65535);
        run_random(110);
        // Sender pauses until every signal is in, then carries on with a new series
        set_regs(2, 3, 5, 7, 20000, 15000, 10000, 5000);
        run_random(60);
        drain();
        run_random(60);
        for (int p = 0; p < 7; p++)
        begin
            set_regs($urandom_range(0, 10), $urandom_range(0, 10), $urandom_range(0, 12),
                     $urandom_range(1, 14),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(1, 65536),
                     $urandom_range(1, 65536), $urandom_range(1, 65536),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(1, 65536));
            run_random(100);
        end
    endtask

    initial
    begin
        fail_count = 0;
        items_sent = 0;
        signals_seen = 0;
        faults_seen = 0;
        restarts_sent = 0;
        cycle_count = 0;
        burst_left = 0;
        walk_price = 32'h0064_0000;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_random_phases();
        test_edge_prices();
        test_unused_index();
        drain();
        $display("Sent %0d price words (%0d restarts) over lag and weight settings;",
                 items_sent, restarts_sent);
        $display("checked %0d signal words, %0d with the zero-price fault.",
                 signals_seen, faults_seen);
        if (fail_count == 0)
            $display("know_sure_thing_oscillator_tb: PASS");
        else
            $display("know_sure_thing_oscillator_tb: FAIL");
        $finish;
    end

endmodule
